// ----- hdl/decimal_argument_validator_assert.svh -----
// Assertion macros for the decimal argument validator.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef DECIMAL_ARGUMENT_VALIDATOR_ASSERT_SVH
`define DECIMAL_ARGUMENT_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
`define DAV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DAV_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DAV_ASSERT(label, prop, msg)
`define DAV_NEVER(label, cond, msg)
`endif
`endif

// ----- hdl/dav_pkg.sv -----
`timescale 1ns / 1ps

package dav_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LIMIT_W = 31;
  localparam int unsigned ACC_W   = LIMIT_W + 1;

  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RESET = 31'h7FFF_FFFF;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam int unsigned RADIX = 10;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NAN    = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_NOTPOS = 2'd3
  } status_t;

endpackage

// ----- hdl/decimal_argument_validator.sv -----
`timescale 1ns / 1ps
//
// Channel  Dir  Handshake            Payload
// -------  ---  -------------------  ------------------------------------
// in       in   in_valid / in_ready  in_char_code[7:0]
// out      out  out_valid/out_ready  out_value[30:0], out_status[1:0]
// cfg      in   cfg_we               cfg_wdata[30:0] (upper_limit)
//
// One character request per cycle unless a terminator waits on a stalled result:
// a character lands in the input register, then the parse step (x10 via
// shift-add, add, saturate compare) updates the parser state from it. A
// terminator also loads the result register once that register is free.
// Reset (rst_n low, synchronous) clears the parser, both valid flags and sets
// upper_limit to its maximum. A stalled result only holds back a terminator;
// while one waits in the input register, no new character is taken.
//

`include "decimal_argument_validator_assert.svh"

module decimal_argument_validator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dav_pkg::CHAR_W-1:0]       in_char_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dav_pkg::LIMIT_W-1:0]      out_value,
  output dav_pkg::status_t                 out_status,
  input  logic                             cfg_we,
  input  logic [dav_pkg::LIMIT_W-1:0]      cfg_wdata
);

  import dav_pkg::*;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

  localparam int unsigned PROD_W = ACC_W + 4;  // holds acc*10 + 9 for acc <= 2^31

  // registers
  logic [LIMIT_W-1:0] upper_limit_r, upper_limit_nxt;
  logic               char_valid_r, char_valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  phase_t             phase_r, phase_nxt;
  logic               negative_r, negative_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LIMIT_W-1:0] out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;

  // datapath
  logic               in_fire;
  logic               out_free;
  logic               is_term;
  logic               proc;
  logic               is_digit;
  logic               is_space;
  logic               is_sign;
  logic [3:0]         digit_full;
  logic [PROD_W-1:0]  acc_ext;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  cap_ext;
  logic [ACC_W-1:0]   cap;
  logic [ACC_W-1:0]   acc_digit;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_term  = (char_r == CHAR_NUL);
  // a terminator waits for the result register; anything else goes through
  assign proc     = char_valid_r && (!is_term || out_free);
  assign in_ready = !char_valid_r || proc;

  assign is_digit   = (char_r >= CHAR_ZERO) && (char_r <= CHAR_NINE);
  assign is_space   = (char_r == CHAR_SPACE) || ((char_r >= CHAR_TAB) && (char_r <= CHAR_CR));
  assign is_sign    = (char_r == CHAR_PLUS) || (char_r == CHAR_MINUS);
  assign digit_full = char_r[3:0];  // '0' is 0x30, so the low nibble is the digit

  // acc*10 as (acc<<3)+(acc<<1), then saturate at upper_limit+1
  assign acc_ext = {{(PROD_W-ACC_W){1'b0}}, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1)
                 + {{(PROD_W-4){1'b0}}, digit_full};
  assign cap     = {1'b0, upper_limit_r} + {{(ACC_W-1){1'b0}}, 1'b1};
  assign cap_ext = {{(PROD_W-ACC_W){1'b0}}, cap};
  assign acc_digit = (prod > cap_ext) ? cap : prod[ACC_W-1:0];

  always_comb begin
    upper_limit_nxt = cfg_we ? cfg_wdata : upper_limit_r;

    char_nxt       = in_fire ? in_char_code : char_r;
    char_valid_nxt = in_fire ? 1'b1 : (proc ? 1'b0 : char_valid_r);

    phase_nxt    = phase_r;
    negative_nxt = negative_r;
    acc_nxt      = acc_r;

    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    if (proc) begin
      if (is_term) begin
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        if (phase_r != PH_DIGITS) begin
          out_status_nxt = ST_NAN;
        end else if (negative_r || (acc_r == '0)) begin
          out_status_nxt = ST_NOTPOS;            // zero, "-0" and any negative
        end else if (acc_r > {1'b0, upper_limit_r}) begin
          out_status_nxt = ST_ABOVE;
        end else begin
          out_status_nxt = ST_OK;
          out_value_nxt  = acc_r[LIMIT_W-1:0];
        end
        phase_nxt    = PH_SPACE;
        negative_nxt = 1'b0;
        acc_nxt      = '0;
      end else begin
        unique case (phase_r)
          PH_SPACE: begin
            if (is_space) begin
              phase_nxt = PH_SPACE;
            end else if (is_sign) begin
              negative_nxt = (char_r == CHAR_MINUS);
              phase_nxt    = PH_SIGN;
            end else if (is_digit) begin
              acc_nxt   = acc_digit;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              acc_nxt   = acc_digit;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          default: begin
            phase_nxt = PH_BAD;                  // malformed sticks until the terminator
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= UPPER_LIMIT_RESET;
      char_valid_r  <= 1'b0;
      phase_r       <= PH_SPACE;
      negative_r    <= 1'b0;
      acc_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      upper_limit_r <= upper_limit_nxt;
      char_valid_r  <= char_valid_nxt;
      phase_r       <= phase_nxt;
      negative_r    <= negative_nxt;
      acc_r         <= acc_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    char_r       <= char_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // checks
  `DAV_ASSERT(a_space_clean, (phase_r == PH_SPACE) |-> ((acc_r == '0) && !negative_r),
              "whitespace phase with stale accumulator or sign")
  `DAV_ASSERT(a_sign_clean, (phase_r == PH_SIGN) |-> (acc_r == '0),
              "sign phase with nonzero accumulator")
  `DAV_ASSERT(a_ok_nonzero, (out_valid_r && (out_status_r == ST_OK)) |-> (out_value_r != '0),
              "ok result with zero value")
  `DAV_ASSERT(a_err_zero, (out_valid_r && (out_status_r != ST_OK)) |-> (out_value_r == '0),
              "error result with nonzero value")
  `DAV_NEVER(a_status_known, out_valid_r && $isunknown(out_status_r),
             "result offered with unknown status")

endmodule
